>>> design/qls_pkg.sv
// qls_pkg: shared types and codes for the query latency and size statistics block.
// No dependencies; qls_front, qls_back, the top level and the bench refer to it by scoped names.
package qls_pkg;

  // action codes on the input channel
  localparam logic [2:0] ACT_ENABLE  = 3'd0;
  localparam logic [2:0] ACT_DISABLE = 3'd1;
  localparam logic [2:0] ACT_START   = 3'd2;
  localparam logic [2:0] ACT_STOP    = 3'd3;
  localparam logic [2:0] ACT_TICK    = 3'd4;

  // depth of the command queue between front and back
  localparam int QDEPTH = 2;

  // classified command, as handed from front to back
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ENABLE,
    CMD_DISABLE,
    CMD_START,
    CMD_STOP_FAIL,
    CMD_STOP_OK,
    CMD_TICK
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] byte_count;
  } cmd_word_t;

  // back-end sequencer
  typedef enum logic [1:0] {
    BST_IDLE,
    BST_MUL,
    BST_DIV_START,
    BST_DIV_WAIT
  } bst_t;

  // result word
  typedef struct packed {
    logic        enabled;
    logic [31:0] query_total;
    logic [31:0] error_total;
    logic [31:0] bytes_least;
    logic [31:0] bytes_mean;
    logic [31:0] bytes_most;
    logic [31:0] millis_least;
    logic [31:0] millis_mean;
    logic [31:0] millis_most;
  } snap_t;

endpackage

>>> design/qls_ifs.sv
// qls_ifs: valid/ready channel interfaces for the input and result words.
// Depends on nothing; used by the front, the top level and the bench.
interface qls_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] byte_count;

  modport source (output valid, output action, output byte_count, input ready);
  modport sink   (input valid, input action, input byte_count, output ready);
endinterface

interface qls_out_if;
  logic        valid;
  logic        ready;
  logic        enabled;
  logic [31:0] query_total;
  logic [31:0] error_total;
  logic [31:0] bytes_least;
  logic [31:0] bytes_mean;
  logic [31:0] bytes_most;
  logic [31:0] millis_least;
  logic [31:0] millis_mean;
  logic [31:0] millis_most;

  modport source (output valid, output enabled, output query_total, output error_total,
                  output bytes_least, output bytes_mean, output bytes_most,
                  output millis_least, output millis_mean, output millis_most,
                  input ready);
  modport sink   (input valid, input enabled, input query_total, input error_total,
                  input bytes_least, input bytes_mean, input bytes_most,
                  input millis_least, input millis_mean, input millis_most,
                  output ready);
endinterface

>>> design/qls_front.sv
// qls_front: accepts input words, classifies the action and queues commands.
// Depends on qls_pkg and qls_in_if.
module qls_front (
  input  logic               clk,
  input  logic               rst_n,
  qls_in_if.sink             in_ch,
  output logic               cmd_valid,
  output qls_pkg::cmd_word_t cmd_word,
  input  logic               cmd_pop
);

  localparam int PTR_W = $clog2(qls_pkg::QDEPTH);

  qls_pkg::cmd_word_t q_r [qls_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W:0]     count_r;
  qls_pkg::cmd_word_t cls;
  logic               accept;

  assign in_ch.ready = (count_r != (PTR_W+1)'(qls_pkg::QDEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count_r != '0);
  assign cmd_word    = q_r[rd_ptr_r];

  // stop is split here by success, so the back end only looks at the code
  always_comb begin
    cls.byte_count = in_ch.byte_count;
    unique case (in_ch.action)
      qls_pkg::ACT_ENABLE:  cls.cmd = qls_pkg::CMD_ENABLE;
      qls_pkg::ACT_DISABLE: cls.cmd = qls_pkg::CMD_DISABLE;
      qls_pkg::ACT_START:   cls.cmd = qls_pkg::CMD_START;
      qls_pkg::ACT_STOP:    cls.cmd = (in_ch.byte_count == 32'd0) ? qls_pkg::CMD_STOP_FAIL
                                                                   : qls_pkg::CMD_STOP_OK;
      qls_pkg::ACT_TICK:    cls.cmd = qls_pkg::CMD_TICK;
      default:              cls.cmd = qls_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (accept && !cmd_pop) begin
        count_r <= count_r + (PTR_W+1)'(1);
      end else if (!accept && cmd_pop) begin
        count_r <= count_r - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> design/qls_div.sv
// qls_div: restoring divider, one quotient bit per cycle, for the running means.
// Depends on nothing; the caller guarantees the quotient fits in QW bits.
module qls_div #(
  parameter int QW = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [QW+32:0]   num,
  input  logic [32:0]      den,
  output logic             done,
  output logic [QW-1:0]    quot,
  output logic [32:0]      rem
);

  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [32:0]      rem_r;
  logic [QW-1:0]    quo_r;
  logic [32:0]      den_r;
  logic [33:0]      trial;
  logic [33:0]      diff;
  logic             ge;

  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quot  = quo_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // upper part of the numerator is already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[QW+32:QW];
      quo_r <= num[QW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[32:0] : trial[32:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

endmodule

>>> design/qls_back.sv
// qls_back: statistics state, fold sequencer and the result register.
// Depends on qls_pkg and qls_div.
module qls_back #(
  parameter int STAT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  qls_pkg::cmd_word_t cmd_word,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output qls_pkg::snap_t     snap
);

  localparam int          SW         = STAT_WIDTH;
  localparam logic [31:0] BYTE_LIMIT = 32'((64'd1 << SW) - 64'd1);
  localparam logic        SEL_TIME   = 1'b0;
  localparam logic        SEL_BYTES  = 1'b1;

  qls_pkg::bst_t   state_r, state_nxt;
  logic            collecting_r;
  logic            open_r;
  logic [SW-1:0]   elapsed_r;
  logic [31:0]     succ_r;
  logic [31:0]     fail_r;
  logic [SW-1:0]   least_r [2];
  logic [SW-1:0]   mean_r  [2];
  logic [SW-1:0]   most_r  [2];
  logic [SW-1:0]   bval_r;
  logic            sel_r;
  logic [SW+31:0]  prod_r;
  logic            out_valid_r;

  logic            slot_free;
  logic            fold_go;
  logic            fold_done;
  logic            result_set;
  logic            div_start;
  logic            div_done;
  logic [SW+32:0]  div_num;
  logic [32:0]     div_den;
  logic [SW-1:0]   div_quot;
  logic [32:0]     div_rem;
  logic            round_up;
  logic [SW-1:0]   cur_val;
  logic [SW-1:0]   mean_new;
  logic [SW-1:0]   bsat;

  assign slot_free = !out_valid_r || out_ready;
  assign fold_go   = (cmd_word.cmd == qls_pkg::CMD_STOP_OK) && collecting_r && open_r;
  assign cur_val   = (sel_r == SEL_BYTES) ? bval_r : elapsed_r;
  assign div_num   = {1'b0, prod_r} + {33'd0, cur_val};
  assign div_den   = {1'b0, succ_r} + 33'd1;
  assign round_up  = ({div_rem, 1'b0} >= {1'b0, div_den});
  assign mean_new  = div_quot + SW'(round_up);
  assign bsat      = (cmd_word.byte_count > BYTE_LIMIT) ? '1 : cmd_word.byte_count[SW-1:0];

  qls_div #(.QW(SW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qls_pkg::BST_IDLE: begin
        if (cmd_valid && slot_free && fold_go) begin
          state_nxt = qls_pkg::BST_MUL;
        end
      end
      qls_pkg::BST_MUL:       state_nxt = qls_pkg::BST_DIV_START;
      qls_pkg::BST_DIV_START: state_nxt = qls_pkg::BST_DIV_WAIT;
      qls_pkg::BST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (sel_r == SEL_TIME) ? qls_pkg::BST_MUL : qls_pkg::BST_IDLE;
        end
      end
      default:                state_nxt = qls_pkg::BST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_pop    = 1'b0;
    div_start  = 1'b0;
    fold_done  = 1'b0;
    unique case (state_r)
      qls_pkg::BST_IDLE:      cmd_pop   = cmd_valid && slot_free;
      qls_pkg::BST_DIV_START: div_start = 1'b1;
      qls_pkg::BST_DIV_WAIT:  fold_done = div_done;
      default: ;
    endcase
    result_set = (cmd_pop && !fold_go) || (fold_done && (sel_r == SEL_BYTES));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= qls_pkg::BST_IDLE;
      collecting_r <= 1'b0;
      open_r       <= 1'b0;
      elapsed_r    <= '0;
      succ_r       <= '0;
      fail_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        least_r[i] <= '0;
        mean_r[i]  <= '0;
        most_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (result_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd_pop) begin
        unique case (cmd_word.cmd)
          qls_pkg::CMD_ENABLE: begin
            if (!collecting_r) begin
              collecting_r <= 1'b1;
              succ_r       <= '0;
              fail_r       <= '0;
              for (int i = 0; i < 2; i++) begin
                least_r[i] <= '0;
                mean_r[i]  <= '0;
                most_r[i]  <= '0;
              end
            end
          end
          qls_pkg::CMD_DISABLE: collecting_r <= 1'b0;
          qls_pkg::CMD_START: begin
            if (collecting_r) begin
              open_r    <= 1'b1;
              elapsed_r <= '0;
            end
          end
          qls_pkg::CMD_STOP_FAIL: begin
            if (collecting_r && open_r) begin
              fail_r <= fail_r + 32'd1;
              open_r <= 1'b0;
            end
          end
          qls_pkg::CMD_STOP_OK: begin
            if (collecting_r && open_r) begin
              open_r <= 1'b0;
            end
          end
          qls_pkg::CMD_TICK: begin
            if (open_r && (elapsed_r != '1)) begin
              elapsed_r <= elapsed_r + SW'(1);
            end
          end
          default: ;
        endcase
      end
      // least of 0 means unset
      if (fold_done) begin
        if ((least_r[sel_r] == '0) || (cur_val < least_r[sel_r])) begin
          least_r[sel_r] <= cur_val;
        end
        if (cur_val > most_r[sel_r]) begin
          most_r[sel_r] <= cur_val;
        end
        mean_r[sel_r] <= mean_new;
        if (sel_r == SEL_BYTES) begin
          succ_r <= succ_r + 32'd1;
        end
      end
    end
  end

  // time is folded first, then bytes
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      bval_r <= bsat;
      sel_r  <= SEL_TIME;
    end else if (fold_done) begin
      sel_r  <= SEL_BYTES;
    end
    if (state_r == qls_pkg::BST_MUL) begin
      prod_r <= {{SW{1'b0}}, succ_r} * {32'd0, mean_r[sel_r]};
    end
  end

  assign out_valid          = out_valid_r;
  assign snap.enabled       = collecting_r;
  assign snap.query_total   = succ_r;
  assign snap.error_total   = fail_r;
  assign snap.bytes_least   = 32'(least_r[SEL_BYTES]);
  assign snap.bytes_mean    = 32'(mean_r[SEL_BYTES]);
  assign snap.bytes_most    = 32'(most_r[SEL_BYTES]);
  assign snap.millis_least  = 32'(least_r[SEL_TIME]);
  assign snap.millis_mean   = 32'(mean_r[SEL_TIME]);
  assign snap.millis_most   = 32'(most_r[SEL_TIME]);

endmodule

>>> design/query_latency_size_stats_top.sv
// query_latency_size_stats_top: top level of the query statistics block.
// Depends on qls_pkg, qls_ifs, qls_front, qls_back (which holds qls_div).
//
// Usage notes:
//  - in_ch carries one event word (action, byte_count); out_ch returns one
//    statistics snapshot word per event, in order.
//  - The front end classifies each event and parks it in a two-word queue,
//    so in_ch can accept up to two words while a snapshot waits on out_ch.
//  - Enable, disable, start, tick, failed stop, stop with no open query and
//    unused codes: the result word is registered at the edge at which the
//    event leaves the queue; with an open output and no fold under way these
//    sustain one word per cycle.
//  - A successful stop folds elapsed millis and then bytes. Each fold is a
//    32x STAT_WIDTH multiply, an add and a STAT_WIDTH-step restoring divide
//    in the shared divider, and the snapshot appears after the byte fold.
//  - The snapshot sits in the state registers with a valid flag; it holds
//    while out_ch stalls, and no further event is executed until taken.
//  - Reset (rst_n low, synchronous) clears collection, the open query,
//    counts and all statistics, and empties the queue.
module query_latency_size_stats_top #(
  parameter int STAT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  qls_in_if.sink     in_ch,
  qls_out_if.source  out_ch
);

  logic               cmd_valid;
  logic               cmd_pop;
  qls_pkg::cmd_word_t cmd_word;
  logic               out_valid;
  qls_pkg::snap_t     snap;

  // front: accept and classify
  qls_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_word  (cmd_word),
    .cmd_pop   (cmd_pop)
  );

  // back: execute, fold statistics, hold the result word
  qls_back #(.STAT_WIDTH(STAT_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_word  (cmd_word),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .snap      (snap)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.enabled      = snap.enabled;
  assign out_ch.query_total  = snap.query_total;
  assign out_ch.error_total  = snap.error_total;
  assign out_ch.bytes_least  = snap.bytes_least;
  assign out_ch.bytes_mean   = snap.bytes_mean;
  assign out_ch.bytes_most   = snap.bytes_most;
  assign out_ch.millis_least = snap.millis_least;
  assign out_ch.millis_mean  = snap.millis_mean;
  assign out_ch.millis_most  = snap.millis_most;

  // the back end never takes from an empty queue
  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // byte mean stays between least and most
  a_bytes_order: assert property (@(posedge clk) disable iff (!rst_n)
    (snap.bytes_least <= snap.bytes_mean) && (snap.bytes_mean <= snap.bytes_most))
    else $error("byte statistics out of order");

  // zero-length queries leave least unset, so the mean may sit below it;
  // only the bounds against most hold
  a_millis_order: assert property (@(posedge clk) disable iff (!rst_n)
    (snap.millis_least <= snap.millis_most) && (snap.millis_mean <= snap.millis_most))
    else $error("millisecond statistics out of order");

  // a new result never lands while the previous one is still stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ch.ready) |=> out_valid && $stable(snap))
    else $error("result word overwritten while stalled");

endmodule

>>> tb/query_latency_size_stats_top_tb.sv
// query_latency_size_stats_top_tb: self-checking bench for the query statistics block.
// Sends event words on in_ch, predicts each snapshot word and checks out_ch in order.
// Depends on qls_pkg, qls_ifs and query_latency_size_stats_top.
module query_latency_size_stats_top_tb;

  localparam int          STAT_W       = 32;
  localparam logic [31:0] STAT_CEIL    = 32'((64'd1 << STAT_W) - 64'd1);
  localparam int          RANDOM_WORDS = 2000;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  // words accepted in this window are sent and taken with no idling at all
  localparam int          QUIET_LO     = 800;
  localparam int          QUIET_HI     = 1300;
  // idle time at the end, well over what a successful stop needs
  localparam int          DRAIN_CYCLES = 300;
  localparam int          SHOWN_FAULTS = 10;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] byte_count;
  } event_word_t;

  // least, mean, most
  typedef logic [2:0][31:0] trio_t;

  logic clk;
  logic rst_n;

  qls_in_if  in_ch ();
  qls_out_if out_ch ();

  query_latency_size_stats_top #(
    .STAT_WIDTH(STAT_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // event words still to be sent, and snapshot words predicted but not yet seen
  event_word_t    pending[$];
  qls_pkg::snap_t snaps_due[$];

  int words_taken = 0;
  int snaps_seen  = 0;
  int faults      = 0;
  int cycles      = 0;

  // predicted block state
  logic        coll_on;
  logic        q_open;
  logic [31:0] q_millis;
  logic [31:0] ok_count;
  logic [31:0] err_count;
  trio_t       byte_trio;
  trio_t       millis_trio;

  // Fold one sample into a least/mean/most trio, n being the earlier queries.
  // The mean is the exact running mean rounded half up, over an n+1 divisor.
  function automatic trio_t fold_sample(trio_t t, logic [31:0] v, logic [31:0] n);
    logic [64:0] num;
    logic [64:0] den;
    logic [64:0] quo;
    logic [64:0] rem;
    num = 65'(n) * 65'(t[1]) + 65'(v);
    den = 65'(n) + 65'd1;
    quo = num / den;
    rem = num % den;
    if ((rem << 1) >= den) begin
      quo = quo + 65'd1;
    end
    if (quo > 65'(STAT_CEIL)) begin
      quo = 65'(STAT_CEIL);
    end
    // a least of zero means nothing folded yet
    if (t[0] == 32'd0 || v < t[0]) begin
      t[0] = v;
    end
    if (v > t[2]) begin
      t[2] = v;
    end
    t[1] = quo[31:0];
    return t;
  endfunction

  // Advance the predicted state by one event word and return its snapshot.
  function automatic qls_pkg::snap_t apply_event(event_word_t w);
    logic [31:0]    b;
    qls_pkg::snap_t s;
    b = w.byte_count;
    case (w.action)
      qls_pkg::ACT_ENABLE: begin
        // enabling an enabled block clears nothing
        if (!coll_on) begin
          ok_count    = 32'd0;
          err_count   = 32'd0;
          byte_trio   = '0;
          millis_trio = '0;
          coll_on     = 1'b1;
        end
      end
      qls_pkg::ACT_DISABLE: begin
        coll_on = 1'b0;
      end
      qls_pkg::ACT_START: begin
        if (coll_on) begin
          q_open   = 1'b1;
          q_millis = 32'd0;
        end
      end
      qls_pkg::ACT_STOP: begin
        if (coll_on && q_open) begin
          if (b == 32'd0) begin
            err_count = err_count + 32'd1;
          end else begin
            if (b > STAT_CEIL) begin
              b = STAT_CEIL;
            end
            millis_trio = fold_sample(millis_trio, q_millis, ok_count);
            byte_trio   = fold_sample(byte_trio, b, ok_count);
            ok_count    = ok_count + 32'd1;
          end
          q_open = 1'b0;
        end
      end
      qls_pkg::ACT_TICK: begin
        // ticks run whether or not collection is on
        if (q_open && q_millis < STAT_CEIL) begin
          q_millis = q_millis + 32'd1;
        end
      end
      default: begin
      end
    endcase
    s.enabled      = coll_on;
    s.query_total  = ok_count;
    s.error_total  = err_count;
    s.bytes_least  = byte_trio[0];
    s.bytes_mean   = byte_trio[1];
    s.bytes_most   = byte_trio[2];
    s.millis_least = millis_trio[0];
    s.millis_mean  = millis_trio[1];
    s.millis_most  = millis_trio[2];
    return s;
  endfunction

  // Random idling with a chance of about 6 in a hundred, none inside the quiet window.
  function automatic bit take_break(int count);
    return !(count >= QUIET_LO && count < QUIET_HI) && ($urandom_range(99) < 6);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      faults++;
      if (faults <= SHOWN_FAULTS) begin
        $display("snapshot word %0d: %s expected %h, got %h", snaps_seen, name, want, got);
      end
    end
  endtask

  task automatic push_word(logic [2:0] action, logic [31:0] bytes);
    event_word_t w;
    w.action     = action;
    w.byte_count = bytes;
    pending.push_back(w);
  endtask

  // Driver: predicts on each accepted event word, then offers the next one.
  // valid gets exactly one nonblocking write per edge at which it may change.
  always @(posedge clk) begin : driver
    event_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      coll_on     = 1'b0;
      q_open      = 1'b0;
      q_millis    = 32'd0;
      ok_count    = 32'd0;
      err_count   = 32'd0;
      byte_trio   = '0;
      millis_trio = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        snaps_due.push_back(apply_event({in_ch.action, in_ch.byte_count}));
        words_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending.size() != 0 && !take_break(words_taken)) begin
          w = pending.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.action     <= w.action;
          in_ch.byte_count <= w.byte_count;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted snapshot word is checked against the oldest due.
  always @(posedge clk) begin : monitor
    qls_pkg::snap_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (snaps_due.size() == 0) begin
          faults++;
          if (faults <= SHOWN_FAULTS) begin
            $display("snapshot word %0d arrived with none due", snaps_seen);
          end
        end else begin
          want = snaps_due.pop_front();
          check_field("enabled", {31'd0, want.enabled}, {31'd0, out_ch.enabled});
          check_field("query_total", want.query_total, out_ch.query_total);
          check_field("error_total", want.error_total, out_ch.error_total);
          check_field("bytes_least", want.bytes_least, out_ch.bytes_least);
          check_field("bytes_mean", want.bytes_mean, out_ch.bytes_mean);
          check_field("bytes_most", want.bytes_most, out_ch.bytes_most);
          check_field("millis_least", want.millis_least, out_ch.millis_least);
          check_field("millis_mean", want.millis_mean, out_ch.millis_mean);
          check_field("millis_most", want.millis_most, out_ch.millis_most);
        end
        snaps_seen++;
      end
      out_ch.ready <= !take_break(snaps_seen);
    end
  end

  // Watchdog: a hung handshake or a missing snapshot ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("query_latency_size_stats_top_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    int pick;
    int ticks;
    int total;
    in_ch.valid      = 1'b0;
    in_ch.action     = qls_pkg::ACT_TICK;
    in_ch.byte_count = 32'd0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;

    // Directed words: everything ignored while disabled, unused codes,
    // repeated enable, stop with nothing open, zero elapsed time with the
    // widest byte count, smallest byte count, timer restart, failed stop,
    // ticks while disabled and a query left open across a clearing enable.
    push_word(qls_pkg::ACT_TICK, 32'd0);
    push_word(qls_pkg::ACT_START, 32'd0);
    push_word(qls_pkg::ACT_STOP, 32'd5);
    push_word(3'd5, 32'hFFFF_FFFF);
    push_word(3'd6, 32'd0);
    push_word(3'd7, 32'hAAAA_AAAA);
    push_word(qls_pkg::ACT_ENABLE, 32'd0);
    push_word(qls_pkg::ACT_ENABLE, 32'd0);
    push_word(qls_pkg::ACT_STOP, 32'd9);
    push_word(qls_pkg::ACT_START, 32'd0);
    push_word(qls_pkg::ACT_STOP, 32'hFFFF_FFFF);
    push_word(qls_pkg::ACT_START, 32'd0);
    repeat (3) push_word(qls_pkg::ACT_TICK, 32'd0);
    push_word(qls_pkg::ACT_STOP, 32'd1);
    push_word(qls_pkg::ACT_START, 32'd0);
    push_word(qls_pkg::ACT_TICK, 32'd0);
    push_word(qls_pkg::ACT_START, 32'd0);
    push_word(qls_pkg::ACT_TICK, 32'd0);
    push_word(qls_pkg::ACT_STOP, 32'd0);
    push_word(qls_pkg::ACT_START, 32'd0);
    push_word(qls_pkg::ACT_TICK, 32'd0);
    push_word(qls_pkg::ACT_DISABLE, 32'd0);
    push_word(qls_pkg::ACT_TICK, 32'd0);
    push_word(qls_pkg::ACT_ENABLE, 32'd0);
    push_word(qls_pkg::ACT_STOP, 32'h5555_5555);

    // Random part: mostly whole queries with random timing and sizes,
    // some fresh collections, and the rest raw noise of any code.
    total = pending.size() + RANDOM_WORDS;
    while (pending.size() < total) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if ($urandom_range(9) == 0) begin
          push_word(qls_pkg::ACT_ENABLE, $urandom);
        end
        push_word(qls_pkg::ACT_START, $urandom);
        ticks = ($urandom_range(39) == 0) ? $urandom_range(200) : $urandom_range(12);
        repeat (ticks) push_word(qls_pkg::ACT_TICK, $urandom);
        pick = $urandom_range(99);
        if (pick < 10) begin
          push_word(qls_pkg::ACT_STOP, 32'd0);
        end else if (pick < 40) begin
          push_word(qls_pkg::ACT_STOP, $urandom_range(1000, 1));
        end else if (pick < 48) begin
          push_word(qls_pkg::ACT_STOP, 32'hFFFF_FFFF - $urandom_range(3));
        end else begin
          push_word(qls_pkg::ACT_STOP, $urandom);
        end
      end else if (pick < 80) begin
        push_word(qls_pkg::ACT_DISABLE, $urandom);
        push_word(qls_pkg::ACT_ENABLE, $urandom);
      end else begin
        push_word(3'($urandom_range(7)), $urandom);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // polled on the falling edge so the rising-edge blocks have settled
    while (pending.size() != 0 || in_ch.valid || snaps_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (faults == 0) begin
      $display("query_latency_size_stats_top_tb passed");
    end else begin
      $display("query_latency_size_stats_top_tb failed");
    end
    $finish;
  end

endmodule
